// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the port-level checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable
`define SBA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, without a reset disable
`define SBA_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/sba_pkg.sv
// ---------------------------------------------------------------------------
// sba_pkg
// Shared widths, codes and the controller command word of the allocator.
// ---------------------------------------------------------------------------
package sba_pkg;

  // Default sizes
  localparam int NUM_FRAMES_DEF = 16;
  localparam int MAX_SLOTS_DEF  = 64;

  // Fixed port field widths
  localparam int BPP_W    = 7;
  localparam int OP_W     = 1;
  localparam int PAGE_W   = 4;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 11;

  localparam logic [BPP_W-1:0] BPP_RESET = 7'd64;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the incoming word, start memory reads
    logic commit;    // update state and load the result word
  } sba_cmd_t;

endpackage

// File: src/slab_block_allocator_top.sv
// Timing: a request is captured in the idle state and committed in the exec state
//   once the result register is free; no new request is taken until that commit,
//   which follows the registered reads of the slot ring and taken-bit memories.
// Reset: synchronous active low; list empties, all frames unused, counts zero,
//   page size 64. Slot memories need no clearing pass.
// ---------------------------------------------------------------------------
// slab_block_allocator_top
// Fixed-size block allocator over page frames, with live and peak counts.
// ---------------------------------------------------------------------------
module slab_block_allocator_top
  import sba_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int MAX_SLOTS  = MAX_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [BPP_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [PAGE_W-1:0]   in_free_page,
  input  logic [SLOT_W-1:0]   in_free_slot,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [PAGE_W-1:0]   out_got_page,
  output logic [SLOT_W-1:0]   out_got_slot,
  output logic [LIVE_W-1:0]   out_live_blocks,
  output logic [LIVE_W-1:0]   out_peak_blocks
);

  sba_cmd_t cmd;

  sba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sba_dpath #(.NUM_FRAMES(NUM_FRAMES), .MAX_SLOTS(MAX_SLOTS)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_opcode       (in_opcode),
    .in_free_page    (in_free_page),
    .in_free_slot    (in_free_slot),
    .out_status      (out_status),
    .out_got_page    (out_got_page),
    .out_got_slot    (out_got_slot),
    .out_live_blocks (out_live_blocks),
    .out_peak_blocks (out_peak_blocks)
  );

endmodule

// File: src/sba_ram.sv
// ---------------------------------------------------------------------------
// sba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module sba_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/sba_ctrl.sv
// ---------------------------------------------------------------------------
// sba_ctrl
// Two-state sequencer: capture a request word, then commit it once the
// result register is free.
// ---------------------------------------------------------------------------
module sba_ctrl
  import sba_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output sba_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign in_stall    = (state_r != S_IDLE);
  assign slot_free   = !out_valid_r || !out_stall;
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.commit  = (state_r == S_EXEC) && slot_free;
  assign out_valid   = out_valid_r;

  // Next state and result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: src/sba_dpath.sv
// ---------------------------------------------------------------------------
// sba_dpath
// Page list, per-frame counters, slot memories and the result register.
// ---------------------------------------------------------------------------
module sba_dpath
  import sba_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int MAX_SLOTS  = MAX_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sba_cmd_t            cmd,
  input  logic                cfg_we,
  input  logic [BPP_W-1:0]    cfg_wdata,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [PAGE_W-1:0]   in_free_page,
  input  logic [SLOT_W-1:0]   in_free_slot,
  output logic [STATUS_W-1:0] out_status,
  output logic [PAGE_W-1:0]   out_got_page,
  output logic [SLOT_W-1:0]   out_got_slot,
  output logic [LIVE_W-1:0]   out_live_blocks,
  output logic [LIVE_W-1:0]   out_peak_blocks
);

  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int LW = FW + 1;
  localparam int AW = FW + SW;
  localparam logic [LW-1:0] NIL = {1'b1, {FW{1'b0}}};

  // Frame state
  logic [NUM_FRAMES-1:0] in_use_r, in_use_nxt, on_list_r, on_list_nxt;
  logic [LW-1:0] succ_r [NUM_FRAMES];
  logic [LW-1:0] succ_nxt [NUM_FRAMES];
  logic [LW-1:0] pred_r [NUM_FRAMES];
  logic [LW-1:0] pred_nxt [NUM_FRAMES];
  logic [CW-1:0] cap_r [NUM_FRAMES];
  logic [CW-1:0] cap_nxt [NUM_FRAMES];
  logic [CW-1:0] fcnt_r [NUM_FRAMES];
  logic [CW-1:0] fcnt_nxt [NUM_FRAMES];
  logic [CW-1:0] fresh_r [NUM_FRAMES];
  logic [CW-1:0] fresh_nxt [NUM_FRAMES];
  logic [SW-1:0] rdp_r [NUM_FRAMES];
  logic [SW-1:0] rdp_nxt [NUM_FRAMES];
  logic [SW-1:0] wrp_r [NUM_FRAMES];
  logic [SW-1:0] wrp_nxt [NUM_FRAMES];
  logic [LW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [LIVE_W-1:0] live_r, live_nxt, peak_r, peak_nxt;
  logic [BPP_W-1:0]  bpp_r;

  // Captured request
  logic [OP_W-1:0]   op_r;
  logic [PAGE_W-1:0] page_r;
  logic [SLOT_W-1:0] slot_r;

  // Result register
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [PAGE_W-1:0]   gpage_r, gpage_nxt;
  logic [SLOT_W-1:0]   gslot_r, gslot_nxt;

  // Memory ports
  logic          ring_we, tk_we, tk_wdata, tk_rdata;
  logic [AW-1:0] ring_waddr, ring_raddr, tk_waddr, tk_raddr;
  logic [SW-1:0] ring_wdata, ring_rdata;

  // Working values
  logic          head_nil, any_free, use_fresh, bad, taken, full_free;
  logic [FW-1:0] head_idx, low_free, fa, fi;
  logic [CW-1:0] cap_cfg, cap_f, fcnt_f, fresh_f;
  logic [SW-1:0] rd_f, sa, si;
  logic [LW-1:0] pf, sf, h1, t1;
  logic [31:0]   pg32;

  assign head_nil = head_r[FW];
  assign head_idx = head_r[FW-1:0];
  assign fi       = FW'(page_r);
  assign si       = SW'(slot_r);

  // Memory read addresses: ring at the head page, taken bit at the freed slot
  assign ring_raddr = {head_idx, rdp_r[head_idx]};
  assign tk_raddr   = cmd.capture ? {FW'(in_free_page), SW'(in_free_slot)} : {fi, si};

  // Lowest unused frame
  always_comb begin
    low_free = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (!in_use_r[i]) low_free = FW'(i);
    end
  end
  assign any_free = ~&in_use_r;

  // Clamped page size
  always_comb begin
    if (bpp_r == '0) cap_cfg = CW'(1);
    else if (32'(bpp_r) > MAX_SLOTS) cap_cfg = CW'(MAX_SLOTS);
    else cap_cfg = CW'(bpp_r);
  end

  // Step update
  always_comb begin
    in_use_nxt  = in_use_r;
    on_list_nxt = on_list_r;
    succ_nxt    = succ_r;
    pred_nxt    = pred_r;
    cap_nxt     = cap_r;
    fcnt_nxt    = fcnt_r;
    fresh_nxt   = fresh_r;
    rdp_nxt     = rdp_r;
    wrp_nxt     = wrp_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    live_nxt    = live_r;
    peak_nxt    = peak_r;
    status_nxt  = status_r;
    gpage_nxt   = gpage_r;
    gslot_nxt   = gslot_r;
    ring_we     = 1'b0;
    ring_waddr  = {fi, wrp_r[fi]};
    ring_wdata  = si;
    tk_we       = 1'b0;
    tk_wdata    = 1'b0;
    tk_waddr    = {fi, si};
    fa          = head_nil ? low_free : head_idx;
    cap_f       = head_nil ? cap_cfg : cap_r[fa];
    fcnt_f      = head_nil ? cap_cfg : fcnt_r[fa];
    fresh_f     = head_nil ? '0 : fresh_r[fa];
    rd_f        = head_nil ? '0 : rdp_r[fa];
    use_fresh   = fresh_f < cap_f;
    sa          = use_fresh ? SW'(fresh_f) : ring_rdata;
    taken       = (32'(slot_r) < 32'(fresh_r[fi])) && tk_rdata;
    bad         = (32'(page_r) >= NUM_FRAMES) || !in_use_r[fi] ||
                  (32'(slot_r) >= 32'(cap_r[fi])) || !taken;
    full_free   = (32'(fcnt_r[fi]) + 32'd1) >= 32'(cap_r[fi]);
    pf          = pred_r[fi];
    sf          = succ_r[fi];
    h1          = head_r;
    t1          = tail_r;
    pg32        = 32'(fa);

    if (cmd.commit) begin
      gpage_nxt = '0;
      gslot_nxt = '0;
      if (op_r == OP_ALLOC) begin
        if (head_nil && !any_free) begin
          status_nxt = ST_NO_FRAME;
        end else begin
          status_nxt    = ST_OK;
          gpage_nxt     = pg32[PAGE_W-1:0];
          gslot_nxt     = SLOT_W'(sa);
          in_use_nxt[fa] = 1'b1;
          cap_nxt[fa]   = cap_f;
          fcnt_nxt[fa]  = fcnt_f - CW'(1);
          fresh_nxt[fa] = use_fresh ? fresh_f + CW'(1) : fresh_f;
          if (use_fresh) rdp_nxt[fa] = rd_f;
          else if (32'(rd_f) + 32'd1 >= MAX_SLOTS) rdp_nxt[fa] = '0;
          else rdp_nxt[fa] = rd_f + SW'(1);
          if (head_nil) wrp_nxt[fa] = '0;
          tk_we    = 1'b1;
          tk_wdata = 1'b1;
          tk_waddr = {fa, sa};
          if (fcnt_f == CW'(1)) begin
            // page exhausted: leaves (or never joins) the list
            if (!head_nil) begin
              head_nxt = succ_r[fa];
              if (succ_r[fa][FW]) tail_nxt = NIL;
              else pred_nxt[succ_r[fa][FW-1:0]] = NIL;
              on_list_nxt[fa] = 1'b0;
            end
          end else if (head_nil) begin
            // fresh page becomes the only list entry
            head_nxt        = {1'b0, fa};
            tail_nxt        = {1'b0, fa};
            succ_nxt[fa]    = NIL;
            pred_nxt[fa]    = NIL;
            on_list_nxt[fa] = 1'b1;
          end
          live_nxt = live_r + LIVE_W'(1);
          if (live_nxt > peak_r) peak_nxt = live_nxt;
        end
      end else if (bad) begin
        status_nxt = ST_BAD_FREE;
      end else begin
        status_nxt   = ST_OK;
        tk_we        = 1'b1;
        ring_we      = 1'b1;
        fcnt_nxt[fi] = fcnt_r[fi] + CW'(1);
        if (32'(wrp_r[fi]) + 32'd1 >= MAX_SLOTS) wrp_nxt[fi] = '0;
        else wrp_nxt[fi] = wrp_r[fi] + SW'(1);
        live_nxt = live_r - LIVE_W'(1);
        // unlink the page
        if (on_list_r[fi]) begin
          if (pf[FW]) h1 = sf;
          else succ_nxt[pf[FW-1:0]] = sf;
          if (sf[FW]) t1 = pf;
          else pred_nxt[sf[FW-1:0]] = pf;
          on_list_nxt[fi] = 1'b0;
        end
        if (full_free) begin
          in_use_nxt[fi] = 1'b0;
          head_nxt       = h1;
          tail_nxt       = t1;
        end else begin
          // re-append at the tail
          succ_nxt[fi] = NIL;
          pred_nxt[fi] = t1;
          if (t1[FW]) h1 = {1'b0, fi};
          else succ_nxt[t1[FW-1:0]] = {1'b0, fi};
          head_nxt        = h1;
          tail_nxt        = {1'b0, fi};
          on_list_nxt[fi] = 1'b1;
        end
      end
    end
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r  <= '0;
      on_list_r <= '0;
      head_r    <= NIL;
      tail_r    <= NIL;
      live_r    <= '0;
      peak_r    <= '0;
      bpp_r     <= BPP_RESET;
    end else begin
      in_use_r  <= in_use_nxt;
      on_list_r <= on_list_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      live_r    <= live_nxt;
      peak_r    <= peak_nxt;
      if (cfg_we) bpp_r <= cfg_wdata;
    end
  end

  // Payload state, valid only once written
  always_ff @(posedge clk) begin
    succ_r   <= succ_nxt;
    pred_r   <= pred_nxt;
    cap_r    <= cap_nxt;
    fcnt_r   <= fcnt_nxt;
    fresh_r  <= fresh_nxt;
    rdp_r    <= rdp_nxt;
    wrp_r    <= wrp_nxt;
    status_r <= status_nxt;
    gpage_r  <= gpage_nxt;
    gslot_r  <= gslot_nxt;
    if (cmd.capture) begin
      op_r   <= in_opcode;
      page_r <= in_free_page;
      slot_r <= in_free_slot;
    end
  end

  // Returned slot rings, one region per frame
  sba_ram #(.WIDTH(SW), .ADDR_W(AW)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // Slot taken bits, meaningful below the fresh counter only
  sba_ram #(.WIDTH(1), .ADDR_W(AW)) u_taken (
    .clk   (clk),
    .we    (tk_we),
    .waddr (tk_waddr),
    .wdata (tk_wdata),
    .raddr (tk_raddr),
    .rdata (tk_rdata)
  );

  assign out_status      = status_r;
  assign out_got_page    = gpage_r;
  assign out_got_slot    = gslot_r;
  assign out_live_blocks = live_r;
  assign out_peak_blocks = peak_r;

endmodule

// File: src/sba_checker.sv
// ---------------------------------------------------------------------------
// sba_checker
// Port-level checks on the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sba_checker
  import sba_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_status,
  input logic [PAGE_W-1:0]   out_got_page,
  input logic [SLOT_W-1:0]   out_got_slot,
  input logic [LIVE_W-1:0]   out_live_blocks,
  input logic [LIVE_W-1:0]   out_peak_blocks
);

  // a stalled result word stays offered
  `SBA_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped")
  // one request in flight: busy right after an accept
  `SBA_ASSERT(a_busy, clk, rst_n, in_valid && !in_stall |=> in_stall, "accepted while busy")
  // failed steps report no block
  `SBA_ASSERT(a_fail_zero, clk, rst_n, out_valid && out_status != ST_OK |-> out_got_page == '0 && out_got_slot == '0, "failed step gave a block")
  // peak never trails live
  `SBA_ASSERT(a_peak, clk, rst_n, out_valid |-> out_peak_blocks >= out_live_blocks, "peak below live")
  // the live count does not move while a word waits
  `SBA_ASSERT(a_cnt_hold, clk, rst_n, out_valid && out_stall |=> $stable(out_live_blocks), "live moved under stall")

endmodule

bind slab_block_allocator_top sba_checker u_sba_checker (.*);

// File: bench/sba_checker.sv
// ---------------------------------------------------------------------------
// sba_scoreboard
// Watches the request, result and page size ports of the allocator, keeps
// its own copy of the frame list and slot state, works out the result of
// every accepted word and compares each result word in order, field by field.
// ---------------------------------------------------------------------------
module sba_scoreboard
  import sba_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [BPP_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [PAGE_W-1:0]   in_free_page,
  input  logic [SLOT_W-1:0]   in_free_slot,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [PAGE_W-1:0]   out_got_page,
  input  logic [SLOT_W-1:0]   out_got_slot,
  input  logic [LIVE_W-1:0]   out_live_blocks,
  input  logic [LIVE_W-1:0]   out_peak_blocks,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES = NUM_FRAMES_DEF;
  localparam int SLOTS  = MAX_SLOTS_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page;
    logic [SLOT_W-1:0]   slot;
    logic [LIVE_W-1:0]   live;
    logic [LIVE_W-1:0]   peak;
  } alloc_word_t;

  alloc_word_t expected_words[$];

  // allocator shadow state
  logic [BPP_W-1:0] page_size;
  bit   in_use[FRAMES];
  bit   listed[FRAMES];
  int   succ[FRAMES];
  int   pred[FRAMES];
  int   head, tail;
  int   capacity[FRAMES];
  int   free_cnt[FRAMES];
  int   fresh_cnt[FRAMES];
  int   rd_ptr[FRAMES];
  int   wr_ptr[FRAMES];
  int   returned[FRAMES][SLOTS];
  bit   taken[FRAMES][SLOTS];
  int   live_cnt, peak_cnt;

  assign pending = expected_words.size();

  task automatic unlink_page(input int f);
    if (listed[f]) begin
      if (pred[f] < 0) head = succ[f]; else succ[pred[f]] = succ[f];
      if (succ[f] < 0) tail = pred[f]; else pred[succ[f]] = pred[f];
      listed[f] = 0;
    end
  endtask

  task automatic append_page(input int f);
    succ[f] = -1;
    pred[f] = tail;
    if (tail < 0) head = f; else succ[tail] = f;
    tail = f;
    listed[f] = 1;
  endtask

  // work out the result word of one request and update the shadow state
  task automatic serve_request(input logic [OP_W-1:0] op, input int pg, input int sl);
    alloc_word_t w;
    int f, s;
    w = '0;
    if (op == OP_ALLOC) begin
      f = -1;
      if (head < 0) begin
        for (int i = FRAMES - 1; i >= 0; i--)
          if (!in_use[i]) f = i;
        if (f >= 0) begin
          capacity[f] = (page_size < 1) ? 1 : (page_size > SLOTS) ? SLOTS : page_size;
          in_use[f] = 1;
          free_cnt[f] = capacity[f];
          fresh_cnt[f] = 0;
          rd_ptr[f] = 0;
          wr_ptr[f] = 0;
          append_page(f);
        end
      end
      if (head < 0) begin
        w.status = ST_NO_FRAME;
      end else begin
        f = head;
        if (fresh_cnt[f] < capacity[f]) begin
          s = fresh_cnt[f];
          fresh_cnt[f]++;
        end else begin
          s = returned[f][rd_ptr[f]];
          rd_ptr[f] = (rd_ptr[f] + 1) % SLOTS;
        end
        taken[f][s] = 1;
        free_cnt[f]--;
        if (free_cnt[f] == 0) unlink_page(f);
        live_cnt++;
        if (live_cnt > peak_cnt) peak_cnt = live_cnt;
        w.status = ST_OK;
        w.page = PAGE_W'(f);
        w.slot = SLOT_W'(s);
      end
    end else if (!in_use[pg] || sl >= capacity[pg] || !taken[pg][sl]) begin
      w.status = ST_BAD_FREE;
    end else begin
      taken[pg][sl] = 0;
      returned[pg][wr_ptr[pg]] = sl;
      wr_ptr[pg] = (wr_ptr[pg] + 1) % SLOTS;
      free_cnt[pg]++;
      live_cnt--;
      unlink_page(pg);
      if (free_cnt[pg] >= capacity[pg]) in_use[pg] = 0;
      else append_page(pg);
      w.status = ST_OK;
    end
    w.live = LIVE_W'(live_cnt);
    w.peak = LIVE_W'(peak_cnt);
    expected_words.push_back(w);
  endtask

  always @(posedge clk) begin
    alloc_word_t e, a;
    if (!rst_n) begin
      page_size = BPP_RESET;
      head = -1;
      tail = -1;
      live_cnt = 0;
      peak_cnt = 0;
      for (int i = 0; i < FRAMES; i++) begin
        in_use[i] = 0;
        listed[i] = 0;
        capacity[i] = 0;
        for (int j = 0; j < SLOTS; j++) taken[i][j] = 0;
      end
      expected_words.delete();
      errors = 0;
    end else begin
      // results leave before new requests are predicted
      if (out_valid && !out_stall) begin
        a = '{out_status, out_got_page, out_got_slot, out_live_blocks, out_peak_blocks};
        if (expected_words.size() == 0) begin
          $display("%0t: result word with none expected: %p", $time, a);
          errors++;
        end else begin
          e = expected_words.pop_front();
          if (e.status != a.status)
            $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
          if (e.page != a.page)
            $display("%0t: got_page expected %0d actual %0d", $time, e.page, a.page);
          if (e.slot != a.slot)
            $display("%0t: got_slot expected %0d actual %0d", $time, e.slot, a.slot);
          if (e.live != a.live)
            $display("%0t: live_blocks expected %0d actual %0d", $time, e.live, a.live);
          if (e.peak != a.peak)
            $display("%0t: peak_blocks expected %0d actual %0d", $time, e.peak, a.peak);
          if (e != a) errors++;
        end
      end
      if (in_valid && !in_stall)
        serve_request(in_opcode, in_free_page, in_free_slot);
      if (cfg_we) page_size = cfg_wdata;
    end
  end

endmodule

// File: bench/tb.sv
// ---------------------------------------------------------------------------
// tb
// Drives the slab allocator with directed and random allocate and free words
// over several page sizes and idle patterns; the checker judges the results.
// ---------------------------------------------------------------------------
module tb;
  import sba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic                clk = 0;
  logic                rst_n = 0;
  logic                cfg_we = 0;
  logic [BPP_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 0;
  logic                in_stall;
  logic [OP_W-1:0]     in_opcode = OP_ALLOC;
  logic [PAGE_W-1:0]   in_free_page = '0;
  logic [SLOT_W-1:0]   in_free_slot = '0;
  logic                out_valid;
  logic                out_stall = 0;
  logic [STATUS_W-1:0] out_status;
  logic [PAGE_W-1:0]   out_got_page;
  logic [SLOT_W-1:0]   out_got_slot;
  logic [LIVE_W-1:0]   out_live_blocks;
  logic [LIVE_W-1:0]   out_peak_blocks;
  int                  errors, pending;

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  int cycles = 0;

  // ops in flight, and blocks seen handed out (may go stale)
  logic [OP_W-1:0] ops_in_flight[$];
  logic [PAGE_W+SLOT_W-1:0] block_pool[$];

  always #10 clk = ~clk;

  slab_block_allocator_top DUT (.*);

  sba_scoreboard u_checker (.*);

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // track handed-out blocks so frees mostly hit live ones
  always @(posedge clk) begin
    logic [OP_W-1:0] op;
    if (rst_n) begin
      if (out_valid && !out_stall && ops_in_flight.size() > 0) begin
        op = ops_in_flight.pop_front();
        if (op == OP_ALLOC && out_status == ST_OK)
          block_pool.push_back({out_got_page, out_got_slot});
      end
      if (in_valid && !in_stall) ops_in_flight.push_back(in_opcode);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    int hold_left;
    if (hold_req && hold_left == 0) hold_left = 300;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_word(input logic [OP_W-1:0] op, input int pg, input int sl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_opcode = op;
    in_free_page = PAGE_W'(pg);
    in_free_slot = SLOT_W'(sl);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_page_size(input int bpp);
    cfg_we = 1;
    cfg_wdata = BPP_W'(bpp);
    @(negedge clk);
    cfg_we = 0;
  endtask

  // mostly allocate and free live blocks, some stray frees
  task automatic random_word();
    int r, k;
    logic [PAGE_W+SLOT_W-1:0] b;
    r = $urandom_range(99);
    if (r < 55 || (r < 92 && block_pool.size() == 0)) begin
      send_word(OP_ALLOC, $urandom_range(15), $urandom_range(63));
    end else if (r < 92) begin
      k = $urandom_range(block_pool.size() - 1);
      b = block_pool[k];
      block_pool.delete(k);
      send_word(OP_FREE, b[PAGE_W+SLOT_W-1:SLOT_W], b[SLOT_W-1:0]);
    end else begin
      send_word(OP_FREE, $urandom_range(15), $urandom_range(63));
    end
  endtask

  initial begin
    int sizes[7] = '{64, 1, 0, 3, 127, 64, 7};
    repeat (8) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: bad frees on empty and released frames and of an untaken slot, frame release
    send_word(OP_FREE, 15, 63);
    send_word(OP_ALLOC, 0, 0);
    send_word(OP_FREE, 0, 5);
    send_word(OP_FREE, 0, 0);
    send_word(OP_FREE, 0, 0);
    drain();

    // one block per page: run out of frames, slot beyond capacity
    set_page_size(1);
    repeat (17) send_word(OP_ALLOC, 0, 0);
    send_word(OP_FREE, 3, 0);
    send_word(OP_FREE, 4, 1);
    send_word(OP_ALLOC, 0, 0);
    drain();
    while (block_pool.size() > 0) begin
      logic [PAGE_W+SLOT_W-1:0] b;
      b = block_pool.pop_front();
      send_word(OP_FREE, b[PAGE_W+SLOT_W-1:SLOT_W], b[SLOT_W-1:0]);
    end
    drain();

    // random phases over page sizes and idle patterns
    for (int p = 0; p < 7; p++) begin
      set_page_size(sizes[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 80; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 80; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      for (int i = 0; i < 200; i++) begin
        if (p == 1 && i == 20) hold_req = 1;
        if (p == 1 && i == 21) hold_req = 0;
        random_word();
      end
      drain();
    end

    repeat (10) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
